// File: rtl/core/mer_pkg.sv
// Package for the midpoint ellipse rasterizer: sequencer state encoding.
// Used by midpoint_ellipse_rasterizer_unit; depends on nothing else.
package mer_pkg;

  // Sequencer states. Each state issues at most one product to the shared multiplier.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START_A,
    ST_START_B,
    ST_START_C,
    ST_START_D,
    ST_R1_LHS,
    ST_R1_RHS,
    ST_R1_TEST,
    ST_R1_YSTEP,
    ST_R1_DONE,
    ST_R2I_BT,
    ST_R2I_U2,
    ST_R2I_AU,
    ST_R2I_AB,
    ST_R2I_DONE,
    ST_R2_X,
    ST_R2_Y,
    ST_R2_DONE,
    ST_EMIT
  } state_e;

endpackage

// File: rtl/core/mer_mul.sv
// Shared unsigned multiplier of the ellipse rasterizer with a registered product.
// Stand-alone module; instantiated by midpoint_ellipse_rasterizer_unit.
module mer_mul #(
  parameter int W = 22
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   op_a_i,
  input  logic [W-1:0]   op_b_i,
  output logic [2*W-1:0] prod_o
);

  logic [2*W-1:0] prod_q;

  // One product per enabled cycle; it holds until the next issue.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (2 * W)'(op_a_i) * (2 * W)'(op_b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/core/midpoint_ellipse_rasterizer_unit.sv
// Top level of the two-region midpoint ellipse rasterizer.
// Depends on mer_pkg (state encoding) and mer_mul (shared multiplier).
//
//  Channel  | Direction | Moves per transaction
//  s_axis   | in        | tuser = action, tdata = semi axes and centre
//  m_axis   | out       | tdata = four symmetric points, tlast = last group
//
// Each input transaction passes through the sequencer states of its kind (a start,
// a region-one step, a region-two step or the step that switches regions) and ends
// in the emit state. The single shared multiplier takes one product per cycle under
// the sequencer. An advance with no active ellipse emits nothing.
// Reset clears the sequencer and the active flag; the result register holds a
// waiting transaction while m_axis_tready_i is low and the sequencer then stalls in
// its emit state, with s_axis_tready_o low.
module midpoint_ellipse_rasterizer_unit #(
  parameter int AXIS_BITS  = 10,
  parameter int COORD_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input stream
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // tdata: semi_axis_x, semi_axis_y, center_x, center_y, zero padding
  input  logic [((2*AXIS_BITS+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: action (0 start, 1 advance)
  input  logic s_axis_tuser_i,
  // Output stream
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // tdata: px_pos_pos, py_pos_pos, px_neg_pos, py_neg_pos,
  //        px_neg_neg, py_neg_neg, px_pos_neg, py_pos_neg, zero padding
  output logic [((8*(COORD_BITS+1)+7)/8)*8-1:0] m_axis_tdata_o,
  // tlast: last_point
  output logic m_axis_tlast_o
);

  localparam int A      = AXIS_BITS;
  localparam int C      = COORD_BITS;
  localparam int OW     = C + 1;
  localparam int SQW    = 2 * A;
  localparam int MW     = 2 * A + 2;
  localparam int PW     = 2 * MW;
  localparam int DW     = 4 * A + 8;
  localparam int XW     = (A > OW) ? A : OW;
  localparam int OUT_TW = ((8 * OW + 7) / 8) * 8;

  mer_pkg::state_e state_q, state_d;

  logic           active_q, active_d;
  logic           region2_q, region2_d;
  logic [A-1:0]   x_q, x_d;
  logic [A-1:0]   y_q, y_d;
  logic [A-1:0]   a_in_q, a_in_d;
  logic [SQW-1:0] a_sq_q, a_sq_d;
  logic [SQW-1:0] b_sq_q, b_sq_d;
  logic [DW-1:0]  d_q, d_d;
  logic [C-1:0]   cx_q, cx_d;
  logic [C-1:0]   cy_q, cy_d;
  logic [PW-1:0]  t_q, t_d;
  logic           neg_q, neg_d;

  logic              out_valid_q, out_valid_d;
  logic [OUT_TW-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic          mul_en;
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;

  logic          in_accept;
  logic          out_free;
  logic          is_start;
  logic          lhs_less;
  logic [A-1:0]  x_inc;
  logic [MW-1:0] xm, ym;
  logic [DW-1:0] prod_e, a_sq_e, b_sq_e;
  logic [OW-1:0] ox, oy, ocx, ocy;
  logic [XW-1:0] x_wide, y_wide;

  // Input field extraction
  logic [A-1:0] in_a, in_b;
  logic [C-1:0] in_cx, in_cy;
  assign in_a  = s_axis_tdata_i[A-1:0];
  assign in_b  = s_axis_tdata_i[2*A-1:A];
  assign in_cx = s_axis_tdata_i[2*A+C-1:2*A];
  assign in_cy = s_axis_tdata_i[2*A+2*C-1:2*A+C];

  assign s_axis_tready_o = (state_q == mer_pkg::ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign is_start        = !s_axis_tuser_i;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Shared multiplier
  mer_mul #(
    .W(MW)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  // Common operand forms and widened copies for the decision adder.
  assign xm       = MW'(x_q);
  assign ym       = MW'(y_q);
  assign prod_e   = DW'(prod);
  assign a_sq_e   = DW'(a_sq_q);
  assign b_sq_e   = DW'(b_sq_q);
  assign x_inc    = (x_q == {A{1'b1}}) ? x_q : x_q + A'(1);
  assign lhs_less = {t_q, 1'b0} < {1'b0, prod};

  // Point coordinates wrap to the output width.
  assign x_wide = XW'(x_q);
  assign y_wide = XW'(y_q);
  assign ox     = x_wide[OW-1:0];
  assign oy     = y_wide[OW-1:0];
  assign ocx    = {cx_q[C-1], cx_q};
  assign ocy    = {cy_q[C-1], cy_q};

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mer_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (is_start) begin
            state_d = mer_pkg::ST_START_A;
          end else if (active_q) begin
            state_d = region2_q ? mer_pkg::ST_R2_X : mer_pkg::ST_R1_LHS;
          end
        end
      end
      mer_pkg::ST_START_A:  state_d = mer_pkg::ST_START_B;
      mer_pkg::ST_START_B:  state_d = mer_pkg::ST_START_C;
      mer_pkg::ST_START_C:  state_d = mer_pkg::ST_START_D;
      mer_pkg::ST_START_D:  state_d = mer_pkg::ST_EMIT;
      mer_pkg::ST_R1_LHS:   state_d = mer_pkg::ST_R1_RHS;
      mer_pkg::ST_R1_RHS:   state_d = mer_pkg::ST_R1_TEST;
      mer_pkg::ST_R1_TEST: begin
        state_d = lhs_less ? mer_pkg::ST_R1_YSTEP : mer_pkg::ST_R2I_BT;
      end
      mer_pkg::ST_R1_YSTEP: state_d = mer_pkg::ST_R1_DONE;
      mer_pkg::ST_R1_DONE:  state_d = mer_pkg::ST_EMIT;
      mer_pkg::ST_R2I_BT:   state_d = mer_pkg::ST_R2I_U2;
      mer_pkg::ST_R2I_U2:   state_d = mer_pkg::ST_R2I_AU;
      mer_pkg::ST_R2I_AU:   state_d = mer_pkg::ST_R2I_AB;
      mer_pkg::ST_R2I_AB:   state_d = mer_pkg::ST_R2I_DONE;
      mer_pkg::ST_R2I_DONE: state_d = mer_pkg::ST_R2_X;
      mer_pkg::ST_R2_X:     state_d = mer_pkg::ST_R2_Y;
      mer_pkg::ST_R2_Y:     state_d = mer_pkg::ST_R2_DONE;
      mer_pkg::ST_R2_DONE:  state_d = mer_pkg::ST_EMIT;
      mer_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = mer_pkg::ST_IDLE;
        end
      end
      default: state_d = mer_pkg::ST_IDLE;
    endcase
  end

  // Datapath control: multiplier issue and register updates for each state.
  always_comb begin
    active_d    = active_q;
    region2_d   = region2_q;
    x_d         = x_q;
    y_d         = y_q;
    a_in_d      = a_in_q;
    a_sq_d      = a_sq_q;
    b_sq_d      = b_sq_q;
    d_d         = d_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    t_d         = t_q;
    neg_d       = neg_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    mul_en      = 1'b0;
    mul_a       = xm;
    mul_b       = ym;
    case (state_q)
      mer_pkg::ST_IDLE: begin
        // A start drops any running ellipse and loads the new one.
        if (in_accept && is_start) begin
          a_in_d    = in_a;
          y_d       = in_b;
          x_d       = '0;
          cx_d      = in_cx;
          cy_d      = in_cy;
          region2_d = 1'b0;
          active_d  = 1'b1;
        end
      end
      mer_pkg::ST_START_A: begin
        mul_en = 1'b1;
        mul_a  = MW'(a_in_q);
        mul_b  = MW'(a_in_q);
      end
      mer_pkg::ST_START_B: begin
        a_sq_d = prod[SQW-1:0];
        mul_en = 1'b1;
        mul_a  = ym;
        mul_b  = ym;
      end
      mer_pkg::ST_START_C: begin
        b_sq_d = prod[SQW-1:0];
        mul_en = 1'b1;
        mul_a  = MW'(a_sq_q);
        mul_b  = ym;
      end
      mer_pkg::ST_START_D: begin
        // D = 4b^2 - 4a^2 b + a^2
        d_d = (b_sq_e << 2) + a_sq_e - (prod_e << 2);
      end
      mer_pkg::ST_R1_LHS: begin
        mul_en = 1'b1;
        mul_a  = MW'(b_sq_q);
        mul_b  = xm + MW'(1);
      end
      mer_pkg::ST_R1_RHS: begin
        t_d    = prod;
        mul_en = 1'b1;
        mul_a  = MW'(a_sq_q);
        mul_b  = (ym << 1) - MW'(1);
      end
      mer_pkg::ST_R1_TEST: begin
        mul_en = 1'b1;
        if (lhs_less) begin
          // Region one continues: b^2 (2x+3).
          neg_d = d_q[DW-1];
          mul_a = MW'(b_sq_q);
          mul_b = (xm << 1) + MW'(3);
        end else begin
          // Region switch: (2x+1)^2 first.
          mul_a = (xm << 1) + MW'(1);
          mul_b = (xm << 1) + MW'(1);
        end
      end
      mer_pkg::ST_R1_YSTEP: begin
        d_d    = d_q + (prod_e << 2);
        mul_en = 1'b1;
        mul_a  = MW'(a_sq_q);
        mul_b  = ym - MW'(1);
      end
      mer_pkg::ST_R1_DONE: begin
        if (!neg_q) begin
          d_d = d_q - (prod_e << 3);
          y_d = y_q - A'(1);
        end
        x_d = x_inc;
      end
      mer_pkg::ST_R2I_BT: begin
        mul_en = 1'b1;
        mul_a  = MW'(b_sq_q);
        mul_b  = prod[MW-1:0];
      end
      mer_pkg::ST_R2I_U2: begin
        d_d    = prod_e;
        mul_en = 1'b1;
        mul_a  = ym - MW'(1);
        mul_b  = ym - MW'(1);
      end
      mer_pkg::ST_R2I_AU: begin
        mul_en = 1'b1;
        mul_a  = MW'(a_sq_q);
        mul_b  = prod[MW-1:0];
      end
      mer_pkg::ST_R2I_AB: begin
        d_d    = d_q + (prod_e << 2);
        mul_en = 1'b1;
        mul_a  = MW'(a_sq_q);
        mul_b  = MW'(b_sq_q);
      end
      mer_pkg::ST_R2I_DONE: begin
        d_d       = d_q - (prod_e << 2);
        region2_d = 1'b1;
      end
      mer_pkg::ST_R2_X: begin
        neg_d  = d_q[DW-1];
        mul_en = 1'b1;
        mul_a  = MW'(b_sq_q);
        mul_b  = xm + MW'(1);
      end
      mer_pkg::ST_R2_Y: begin
        // x step term 8b^2(x+1) only when the decision is negative.
        if (neg_q) begin
          d_d = d_q + (prod_e << 3);
        end
        mul_en = 1'b1;
        mul_a  = MW'(a_sq_q);
        mul_b  = ym - MW'(1);
      end
      mer_pkg::ST_R2_DONE: begin
        // y step term 4a^2(3-2y) written as 4a^2 - 8a^2(y-1).
        d_d = d_q + (a_sq_e << 2) - (prod_e << 3);
        if (neg_q) begin
          x_d = x_inc;
        end
        y_d = y_q - A'(1);
      end
      mer_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = (y_q == '0);
          out_data_d  = OUT_TW'({ocy - oy, ocx + ox,
                                 ocy - oy, ocx - ox,
                                 ocy + oy, ocx - ox,
                                 ocy + oy, ocx + ox});
          if (y_q == '0) begin
            active_d = 1'b0;
          end
        end
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mer_pkg::ST_IDLE;
      active_q    <= 1'b0;
      region2_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      region2_q   <= region2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    a_in_q     <= a_in_d;
    a_sq_q     <= a_sq_d;
    b_sq_q     <= b_sq_d;
    d_q        <= d_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    t_q        <= t_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: tb/sv/midpoint_ellipse_rasterizer_unit_tb.sv
// Self-checking testbench for midpoint_ellipse_rasterizer_unit.
// Depends only on the unit under test; a built-in predictor walks each ellipse and
// every output transaction is compared field by field with the oldest prediction.
module midpoint_ellipse_rasterizer_unit_tb;

  localparam int AXIS_W         = 10;
  localparam int COORD_W        = 12;
  localparam int PT_W           = COORD_W + 1;
  localparam int IN_W           = ((2*AXIS_W+2*COORD_W+7)/8)*8;
  localparam int OUT_W          = ((8*PT_W+7)/8)*8;
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int STALL_LIMIT    = 3000;
  localparam int HOLDOFF_CYCLES = 250;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TOTAL_ITEMS    = 650;
  localparam int QUIET_ITEMS    = 120;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_e;

  // Declared from the top bit down, so that {tlast, tdata} maps straight onto it.
  typedef struct packed {
    logic                   last;
    logic signed [PT_W-1:0] py_pn;
    logic signed [PT_W-1:0] px_pn;
    logic signed [PT_W-1:0] py_nn;
    logic signed [PT_W-1:0] px_nn;
    logic signed [PT_W-1:0] py_np;
    logic signed [PT_W-1:0] px_np;
    logic signed [PT_W-1:0] py_pp;
    logic signed [PT_W-1:0] px_pp;
  } point_group_t;

  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tuser  = 1'b0;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tready = 1'b0;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             m_axis_tlast_o;

  // Shared between the stimulus, the receiver and the checker.
  bit               no_idle     = 1'b0;
  bit               holdoff_req = 1'b0;
  int               errors      = 0;
  int               items_sent  = 0;
  int               stall_count = 0;

  // Predictor state: the walk in progress and the groups still owed by the block.
  bit                        walk_active;
  bit                        walk_region2;
  logic [AXIS_W-1:0]         x_off;
  logic [AXIS_W-1:0]         y_off;
  longint unsigned           a_sq;
  longint unsigned           b_sq;
  longint unsigned           dscaled;
  logic signed [COORD_W-1:0] cx_held;
  logic signed [COORD_W-1:0] cy_held;
  point_group_t              pending_groups[$];

  midpoint_ellipse_rasterizer_unit #(
    .AXIS_BITS (AXIS_W),
    .COORD_BITS(COORD_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Clock.
  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  // Predicts the four symmetric points of the current offset and closes the walk at y = 0.
  function automatic void push_group();
    int           cx;
    int           cy;
    int           dx;
    int           dy;
    point_group_t g;
    cx = cx_held;
    cy = cy_held;
    dx = x_off;
    dy = y_off;
    g.px_pp = PT_W'(cx + dx);
    g.py_pp = PT_W'(cy + dy);
    g.px_np = PT_W'(cx - dx);
    g.py_np = PT_W'(cy + dy);
    g.px_nn = PT_W'(cx - dx);
    g.py_nn = PT_W'(cy - dy);
    g.px_pn = PT_W'(cx + dx);
    g.py_pn = PT_W'(cy - dy);
    g.last  = (y_off == 0);
    if (y_off == 0) walk_active = 1'b0;
    pending_groups.push_back(g);
  endfunction

  function automatic void bump_x();
    if (x_off != '1) x_off = x_off + 1'b1;
  endfunction

  // One midpoint step per transaction; decisions are kept scaled by four, modulo 2^64.
  // Returns whether a point group is owed for this transaction.
  function automatic bit rasterise_item(action_e act, logic [AXIS_W-1:0] ax,
                                        logic [AXIS_W-1:0] ay,
                                        logic signed [COORD_W-1:0] cx,
                                        logic signed [COORD_W-1:0] cy);
    longint unsigned xu;
    longint unsigned yu;
    longint unsigned t;
    longint unsigned u;
    longint unsigned ystep;
    longint          lhs;
    longint          rhs;
    bit              neg;
    if (act == ACT_START) begin
      xu           = ax;
      yu           = ay;
      a_sq         = xu * xu;
      b_sq         = yu * yu;
      cx_held      = cx;
      cy_held      = cy;
      x_off        = '0;
      y_off        = ay;
      walk_region2 = 1'b0;
      dscaled      = 4 * b_sq - 4 * a_sq * yu + a_sq;
      walk_active  = 1'b1;
      push_group();
      return 1'b1;
    end
    if (!walk_active) return 1'b0;

    // Region one: x steps every time, y only when the midpoint lies outside.
    if (!walk_region2) begin
      xu  = x_off;
      yu  = y_off;
      lhs = 2 * longint'(b_sq) * (longint'(xu) + 1);
      rhs = longint'(a_sq) * (2 * longint'(yu) - 1);
      if (lhs < rhs) begin
        neg     = dscaled[63];
        dscaled = dscaled + 4 * b_sq * (2 * xu + 3);
        if (!neg) begin
          dscaled = dscaled + 8 * a_sq - 8 * a_sq * yu;
          y_off   = y_off - 1'b1;
        end
        bump_x();
        push_group();
        return 1'b1;
      end
      t            = 2 * xu + 1;
      u            = yu - 1;
      walk_region2 = 1'b1;
      dscaled      = b_sq * t * t + 4 * a_sq * u * u - 4 * a_sq * b_sq;
    end

    // Region two: y steps every time, x only when the midpoint lies inside.
    xu    = x_off;
    yu    = y_off;
    ystep = 12 * a_sq - 8 * a_sq * yu;
    if (dscaled[63]) begin
      dscaled = dscaled + 4 * b_sq * (2 * xu + 2) + ystep;
      bump_x();
    end else begin
      dscaled = dscaled + ystep;
    end
    y_off = y_off - 1'b1;
    push_group();
    return 1'b1;
  endfunction

  function automatic logic [AXIS_W-1:0] rand_axis();
    return AXIS_W'($urandom_range((1 << AXIS_W) - 1));
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom_range((1 << COORD_W) - 1));
  endfunction

  // Offers one transaction, after a random gap unless idling is switched off, and
  // updates the prediction at the edge where it is accepted.
  task automatic send_item(action_e act, logic [AXIS_W-1:0] ax, logic [AXIS_W-1:0] ay,
                           logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy);
    int gap;
    gap = (!no_idle && $urandom_range(99) < 15) ? $urandom_range(5, 1) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(IN_W-2*AXIS_W-2*COORD_W){1'b0}}, cy, cx, ay, ax};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (rasterise_item(act, ax, ay, cx, cy)) items_sent++;
  endtask

  // Advances the walk in progress, with random contents in the unused fields.
  task automatic walk_ellipse(int max_steps);
    int n;
    n = 0;
    while (walk_active && n < max_steps) begin
      send_item(ACT_ADVANCE, rand_axis(), rand_axis(), rand_coord(), rand_coord());
      n++;
    end
  endtask

  task automatic draw_ellipse(int ax, int ay, logic signed [COORD_W-1:0] cx,
                              logic signed [COORD_W-1:0] cy, int max_steps);
    send_item(ACT_START, AXIS_W'(ax), AXIS_W'(ay), cx, cy);
    walk_ellipse(max_steps);
  endtask

  // Stops offering and waits until every predicted group has been received.
  task automatic wait_for_groups();
    s_tvalid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk_i);
  endtask

  // Degenerate and maximal semi-axes, with the centre at the corners of its range or at the origin.
  task automatic test_extreme_shapes();
    draw_ellipse(0, 0, 12'sh7FF, -12'sh800, 4);
    draw_ellipse(1023, 1023, -12'sh800, 12'sh7FF, 3);
    draw_ellipse(0, 3, 12'sh000, 12'sh000, 10);
    draw_ellipse(1023, 0, 12'sh7FF, 12'sh7FF, 2);
  endtask

  // Advances with no ellipse in progress are dropped, then a complete small ellipse.
  task automatic test_idle_advance();
    walk_ellipse(0);
    send_item(ACT_ADVANCE, rand_axis(), rand_axis(), rand_coord(), rand_coord());
    send_item(ACT_ADVANCE, '1, '1, -12'sh1, -12'sh1);
    draw_ellipse(5, 3, -12'sh1, 12'sh1, 40);
  endtask

  // A start in the middle of a walk abandons it.
  task automatic test_restart_while_busy();
    draw_ellipse(1023, 1, 12'sh7FF, 12'sh7FF, 2);
    draw_ellipse(2, 2, -12'sh800, -12'sh800, 20);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_output_backpressure();
    no_idle     = 1'b1;
    holdoff_req = 1'b1;
    draw_ellipse(20, 15, rand_coord(), rand_coord(), 30);
    no_idle     = 1'b0;
  endtask

  // The sender pauses until the block has delivered everything, then resumes.
  task automatic test_drain_pause();
    draw_ellipse(7, 9, rand_coord(), rand_coord(), 40);
    wait_for_groups();
    repeat ($urandom_range(30, 10)) @(posedge clk_i);
    draw_ellipse(9, 7, rand_coord(), rand_coord(), 40);
  endtask

  // Mostly complete walks of small ellipses; long ones are cut short by the next start,
  // and a few walks are broken off early or followed by stray advances.
  task automatic test_random_walks(int target);
    int shape;
    int ax;
    int ay;
    int cap;
    int quiet_end;
    quiet_end = items_sent + QUIET_ITEMS;
    no_idle   = 1'b1;
    while (items_sent < target) begin
      if (items_sent >= quiet_end) no_idle = 1'b0;
      shape = $urandom_range(99);
      if (shape < 75) begin
        ax = $urandom_range(24);
        ay = $urandom_range(24);
      end else if (shape < 85) begin
        ax = rand_axis();
        ay = $urandom_range(6);
      end else if (shape < 92) begin
        ax = $urandom_range(6);
        ay = rand_axis();
      end else begin
        ax = rand_axis();
        ay = rand_axis();
      end
      cap = (ax > 40 || ay > 40) ? $urandom_range(40, 3) : 200;
      if ($urandom_range(99) < 10) cap = $urandom_range(4);
      draw_ellipse(ax, ay, rand_coord(), rand_coord(), cap);
      if ($urandom_range(99) < 8) begin
        send_item(ACT_ADVANCE, rand_axis(), rand_axis(), rand_coord(), rand_coord());
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random stalls, none while idling is off, and a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        m_tready   <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 15);
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Checks each output transaction against the oldest predicted group.
  always @(posedge clk_i) begin : check_groups
    point_group_t got;
    point_group_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = {m_axis_tlast_o, m_axis_tdata_o[8*PT_W-1:0]};
      if (pending_groups.size() == 0) begin
        $display("%0t: group with nothing predicted, expected none, actual %h",
                 $time, got);
        errors++;
      end else begin
        want = pending_groups.pop_front();
        check_field("px_pos_pos", want.px_pp, got.px_pp);
        check_field("py_pos_pos", want.py_pp, got.py_pp);
        check_field("px_neg_pos", want.px_np, got.px_np);
        check_field("py_neg_pos", want.py_np, got.py_np);
        check_field("px_neg_neg", want.px_nn, got.px_nn);
        check_field("py_neg_neg", want.py_nn, got.py_nn);
        check_field("px_pos_neg", want.px_pn, got.px_pn);
        check_field("py_pos_neg", want.py_pn, got.py_pn);
        check_field("last_point", want.last, got.last);
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Test sequence.
  initial begin
    walk_active  = 1'b0;
    walk_region2 = 1'b0;
    x_off        = '0;
    y_off        = '0;
    a_sq         = 0;
    b_sq         = 0;
    dscaled      = 0;
    cx_held      = '0;
    cy_held      = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extreme_shapes();
    test_idle_advance();
    test_restart_while_busy();
    test_output_backpressure();
    test_drain_pause();
    test_random_walks(TOTAL_ITEMS);

    wait_for_groups();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_groups.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/mer_pkg.sv
rtl/core/mer_mul.sv
rtl/core/midpoint_ellipse_rasterizer_unit.sv
tb/sv/midpoint_ellipse_rasterizer_unit_tb.sv
